// ===== rtl/rfsd_pkg.sv =====
// Package for the register file sensor device.
// Holds request and response structs, access codes, register bit masks and
// the command and status structs shared by controller and datapath.
package rfsd_pkg;

	localparam int REG_COUNT_DEF = 64;
	localparam int MAX_BURST     = 8;
	localparam int CNT_W         = 3;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_SPI   = 3'd3;
	localparam logic [2:0] REQ_MDIO  = 3'd4;

	localparam logic [7:0] ST_READY  = 8'h01;
	localparam logic [7:0] ST_BUSY   = 8'h04;
	localparam logic [7:0] CTL_START = 8'h01;
	localparam logic [7:0] SPI_MASK  = 8'hA5;
	localparam logic [7:0] EP_MAX    = 8'h7F;
	localparam logic [2:0] BUS_MAX   = 3'd3;
	localparam logic [6:0] MDIO_REGS = 7'd32;
	localparam logic [1:0] START_TICKS = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  bus_num;
		logic [7:0]  endpoint;
		logic [6:0]  reg_index;
		logic [6:0]  length;
		logic [63:0] data_word;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] read_data;
		logic        last_result;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic rd_issue;
		logic hi_capture;
		logic wr_byte;
		logic wr_start;
		logic emit;
		logic cnt_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_read;
		logic is_write;
		logic is_spi;
		logic is_mdio;
		logic bad;
		logic last_byte;
		logic emit_last;
		logic cnt_odd;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/register_file_sensor_device_top.sv =====
// Register file sensor device: a byte register file behind a bus access port.
// One access at a time; each read byte passes through a read-issue state for the RAM's registered read.
// A result waits in an output register while the next access is taken in.
// Reset: status register READY, control and countdown zero, RAM valid bits cleared.
module register_file_sensor_device_top #(
	parameter int REG_COUNT = rfsd_pkg::REG_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rfsd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rfsd_pkg::rsp_t rsp
);

	rfsd_pkg::dp_cmd_t  cmd;
	rfsd_pkg::dp_stat_t stat;

	rfsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rfsd_dp #(
		.REG_COUNT(REG_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/rfsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rfsd_ctrl.sv =====
// Access sequencer for the register file sensor device.
// Depends on rfsd_pkg for the command and status structs.
module rfsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rfsd_pkg::dp_stat_t stat,
	output rfsd_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_RDREQ  = 7'b0000100,
		S_MDHI   = 7'b0001000,
		S_WRITE  = 7'b0010000,
		S_WSTART = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_tick) begin
					cmd.tick = 1'b1;
					state_d  = S_IDLE;
				end else if (stat.bad || stat.is_spi) begin
					state_d = S_EMIT;
				end else if (stat.is_read || stat.is_mdio) begin
					state_d = S_RDREQ;
				end else if (stat.is_write) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RDREQ: begin
				cmd.rd_issue = 1'b1;
				if (stat.is_mdio && !stat.cnt_odd) begin
					state_d = S_MDHI;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_MDHI: begin
				cmd.hi_capture = 1'b1;
				cmd.cnt_inc    = 1'b1;
				state_d        = S_RDREQ;
			end
			S_WRITE: begin
				cmd.wr_byte = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (stat.last_byte) begin
					state_d = S_WSTART;
				end
			end
			S_WSTART: begin
				cmd.wr_start = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = stat.is_read ? S_RDREQ : S_EMIT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/rfsd_dp.sv =====
// Datapath for the register file sensor device: request hold, access checks,
// status and control flops, register RAM with valid bits, output register.
// Depends on rfsd_pkg and rfsd_ram.
module rfsd_dp #(
	parameter int REG_COUNT = rfsd_pkg::REG_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rfsd_pkg::req_t     req,
	input  rfsd_pkg::dp_cmd_t  cmd,
	output rfsd_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rfsd_pkg::rsp_t     rsp
);

	localparam int ADDR_W = $clog2(REG_COUNT);

	rfsd_pkg::req_t                req_q;
	logic [rfsd_pkg::CNT_W-1:0]    cnt_q;
	logic [7:0]                    reg0_q;
	logic [7:0]                    reg1_q;
	logic [1:0]                    countdown_q;
	logic [REG_COUNT-1:0]          valid_q;
	logic [ADDR_W-1:0]             rd_addr_q;
	logic                          rd_valid_q;
	logic [7:0]                    hi_q;
	logic                          out_valid_q;
	rfsd_pkg::rsp_t                out_q;

	logic [ADDR_W-1:0] mod_tbl [64];
	logic              ep_ok, win_ok, spi_ok, mdio_ok, bad;
	logic [7:0]        win_end, byte_sum;
	logic [ADDR_W-1:0] byte_addr, mdio_addr, cur_addr;
	logic [7:0]        wr_data, ram_rdata, rd_byte;
	logic              ram_we, covers_ctl;
	rfsd_pkg::rsp_t    rsp_d;

	for (genvar g = 0; g < 64; g++) begin : g_mod
		assign mod_tbl[g] = ADDR_W'(g % REG_COUNT);
	end

	assign ep_ok   = (req_q.bus_num <= rfsd_pkg::BUS_MAX) && (req_q.endpoint <= rfsd_pkg::EP_MAX);
	assign win_end = {1'b0, req_q.reg_index} + {1'b0, req_q.length};
	assign spi_ok  = (req_q.length != 7'd0) && (req_q.length <= 7'(rfsd_pkg::MAX_BURST));
	assign win_ok  = ({1'b0, req_q.reg_index} < 8'(REG_COUNT)) && spi_ok
		&& (win_end <= 8'(REG_COUNT));
	assign mdio_ok = req_q.reg_index < rfsd_pkg::MDIO_REGS;
	assign covers_ctl = (req_q.reg_index <= 7'd1) && (win_end > 8'd1);

	always_comb begin
		case (req_q.req_type) inside
			rfsd_pkg::REQ_TICK:                      bad = 1'b0;
			rfsd_pkg::REQ_READ, rfsd_pkg::REQ_WRITE: bad = !(ep_ok && win_ok);
			rfsd_pkg::REQ_SPI:                       bad = !(ep_ok && spi_ok);
			rfsd_pkg::REQ_MDIO:                      bad = !(ep_ok && mdio_ok);
			default:                                 bad = 1'b1;
		endcase
	end

	assign byte_sum  = {1'b0, req_q.reg_index} + 8'(cnt_q);
	assign byte_addr = byte_sum[ADDR_W-1:0];
	assign mdio_addr = mod_tbl[{req_q.reg_index[4:0], cnt_q[0]}];
	assign cur_addr  = stat.is_mdio ? mdio_addr : byte_addr;
	assign wr_data   = req_q.data_word[{cnt_q, 3'b000} +: 8];
	assign ram_we    = cmd.wr_byte && (byte_sum > 8'd1);

	assign rd_byte = (rd_addr_q == ADDR_W'(0)) ? reg0_q :
		(rd_addr_q == ADDR_W'(1)) ? reg1_q :
		rd_valid_q ? ram_rdata : 8'h00;

	assign stat.is_tick   = (req_q.req_type == rfsd_pkg::REQ_TICK);
	assign stat.is_read   = (req_q.req_type == rfsd_pkg::REQ_READ);
	assign stat.is_write  = (req_q.req_type == rfsd_pkg::REQ_WRITE);
	assign stat.is_spi    = (req_q.req_type == rfsd_pkg::REQ_SPI);
	assign stat.is_mdio   = (req_q.req_type == rfsd_pkg::REQ_MDIO);
	assign stat.bad       = bad;
	assign stat.last_byte = ({4'b0000, cnt_q} == (req_q.length - 7'd1));
	assign stat.emit_last = bad || stat.is_write || stat.is_mdio || stat.last_byte;
	assign stat.cnt_odd   = cnt_q[0];
	assign stat.out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		rsp_d.status      = bad;
		rsp_d.last_result = stat.emit_last;
		rsp_d.read_data   = 16'h0000;
		if (!bad) begin
			if (stat.is_read) begin
				rsp_d.read_data = {8'h00, rd_byte};
			end else if (stat.is_spi) begin
				rsp_d.read_data = {8'h00, wr_data ^ rfsd_pkg::SPI_MASK};
			end else if (stat.is_mdio) begin
				rsp_d.read_data = {hi_q, rd_byte};
			end
		end
	end

	rfsd_ram #(
		.WIDTH(8),
		.DEPTH(REG_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(byte_addr),
		.wdata(wr_data),
		.re   (cmd.rd_issue),
		.raddr(cur_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.rd_issue) begin
			rd_addr_q  <= cur_addr;
			rd_valid_q <= valid_q[cur_addr];
		end
		if (cmd.hi_capture) begin
			hi_q <= rd_byte;
		end
		if (cmd.emit) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			reg0_q      <= rfsd_pkg::ST_READY;
			reg1_q      <= 8'h00;
			countdown_q <= 2'd0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.tick && (countdown_q != 2'd0)) begin
				countdown_q <= countdown_q - 2'd1;
				if (countdown_q == 2'd1) begin
					reg0_q <= (reg0_q & ~rfsd_pkg::ST_BUSY) | rfsd_pkg::ST_READY;
				end
			end
			if (cmd.wr_byte) begin
				if (byte_sum == 8'd0) begin
					reg0_q <= wr_data;
				end else if (byte_sum == 8'd1) begin
					reg1_q <= wr_data;
				end else begin
					valid_q[byte_addr] <= 1'b1;
				end
			end
			if (cmd.wr_start && covers_ctl && ((reg1_q & rfsd_pkg::CTL_START) != 8'h00)) begin
				reg0_q      <= (reg0_q & ~rfsd_pkg::ST_READY) | rfsd_pkg::ST_BUSY;
				reg1_q      <= 8'h00;
				countdown_q <= rfsd_pkg::START_TICKS;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== rtl/rfsd_checker.sv =====
// Port-level checks for the register file sensor device, bound to the top level.
// Depends on rfsd_pkg for the request and response structs.
module rfsd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input rfsd_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input rfsd_pkg::rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("stalled request changed");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous access in decode");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> (rsp.read_data == 16'h0000) && rsp.last_result)
		else $error("error response not a single zero result");

	a_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.read_data[15:8] != 8'h00) |-> !rsp.status && rsp.last_result)
		else $error("wide read word not a single final result");

endmodule

bind register_file_sensor_device_top rfsd_checker u_chk (.*);

// ===== dv/register_file_sensor_device_checker.sv =====
// Response checker for the register file sensor device.
// Mirrors the register file and countdown from accepted request transfers and
// compares every response transfer in order; needs rfsd_pkg.
`timescale 1ns / 100ps
module register_file_sensor_device_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  rfsd_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  rfsd_pkg::rsp_t rsp,
	output int             mismatch_count,
	output int             rsp_outstanding
);

	localparam int NUM_REGS = rfsd_pkg::REG_COUNT_DEF;

	logic [7:0]     shadow_regs [NUM_REGS];
	logic [1:0]     countdown_left;
	rfsd_pkg::rsp_t expected_rsp [$];

	task automatic queue_rsp(input logic status, input logic [15:0] data, input logic last);
		rfsd_pkg::rsp_t item;
		item.status      = status;
		item.read_data   = data;
		item.last_result = last;
		expected_rsp.push_back(item);
	endtask

	function automatic logic route_ok(input rfsd_pkg::req_t r);
		return (r.bus_num <= rfsd_pkg::BUS_MAX) && (r.endpoint <= rfsd_pkg::EP_MAX);
	endfunction

	function automatic logic window_ok(input rfsd_pkg::req_t r);
		int base;
		int cnt;
		base = r.reg_index;
		cnt  = r.length;
		return (base < NUM_REGS) && (cnt >= 1) && (cnt <= rfsd_pkg::MAX_BURST) &&
			(base + cnt <= NUM_REGS);
	endfunction

	task automatic model_access(input rfsd_pkg::req_t r);
		int base;
		int cnt;
		base = r.reg_index;
		cnt  = r.length;
		case (r.req_type)
		rfsd_pkg::REQ_TICK: begin
			if (countdown_left != 2'd0) begin
				countdown_left = countdown_left - 2'd1;
				if (countdown_left == 2'd0)
					shadow_regs[0] = (shadow_regs[0] & ~rfsd_pkg::ST_BUSY) |
						rfsd_pkg::ST_READY;
			end
		end
		rfsd_pkg::REQ_READ: begin
			if (!route_ok(r) || !window_ok(r)) begin
				queue_rsp(1'b1, 16'h0000, 1'b1);
			end else begin
				for (int i = 0; i < cnt; i++)
					queue_rsp(1'b0, {8'h00, shadow_regs[base + i]}, i == cnt - 1);
			end
		end
		rfsd_pkg::REQ_WRITE: begin
			if (!route_ok(r) || !window_ok(r)) begin
				queue_rsp(1'b1, 16'h0000, 1'b1);
			end else begin
				for (int i = 0; i < cnt; i++)
					shadow_regs[base + i] = r.data_word[8 * i +: 8];
				if (base <= 1 && base + cnt > 1 &&
					(shadow_regs[1] & rfsd_pkg::CTL_START) != 8'h00) begin
					shadow_regs[0] = (shadow_regs[0] & ~rfsd_pkg::ST_READY) |
						rfsd_pkg::ST_BUSY;
					shadow_regs[1] = 8'h00;
					countdown_left = rfsd_pkg::START_TICKS;
				end
				queue_rsp(1'b0, 16'h0000, 1'b1);
			end
		end
		rfsd_pkg::REQ_SPI: begin
			if (!route_ok(r) || cnt < 1 || cnt > rfsd_pkg::MAX_BURST) begin
				queue_rsp(1'b1, 16'h0000, 1'b1);
			end else begin
				for (int i = 0; i < cnt; i++)
					queue_rsp(1'b0, {8'h00, r.data_word[8 * i +: 8] ^ rfsd_pkg::SPI_MASK},
						i == cnt - 1);
			end
		end
		rfsd_pkg::REQ_MDIO: begin
			if (!route_ok(r) || r.reg_index >= rfsd_pkg::MDIO_REGS) begin
				queue_rsp(1'b1, 16'h0000, 1'b1);
			end else begin
				queue_rsp(1'b0, {shadow_regs[(2 * base) % NUM_REGS],
					shadow_regs[(2 * base + 1) % NUM_REGS]}, 1'b1);
			end
		end
		default: begin
			queue_rsp(1'b1, 16'h0000, 1'b1);
		end
		endcase
	endtask

	task automatic check_rsp(input rfsd_pkg::rsp_t got);
		rfsd_pkg::rsp_t want;
		if (expected_rsp.size() == 0) begin
			$error("unexpected response: status %0d read_data %h last_result %0d",
				got.status, got.read_data, got.last_result);
			mismatch_count++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, got %h", want.read_data, got.read_data);
				mismatch_count++;
			end
			if (got.last_result !== want.last_result) begin
				$error("last_result: expected %0d, got %0d", want.last_result,
					got.last_result);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_regs[i])
				shadow_regs[i] = 8'h00;
			shadow_regs[0] = rfsd_pkg::ST_READY;
			countdown_left = 2'd0;
			expected_rsp.delete();
			mismatch_count = 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_rsp(rsp);
			if (req_valid && req_ready)
				model_access(req);
		end
		rsp_outstanding = expected_rsp.size();
	end

endmodule

// ===== dv/register_file_sensor_device_top_test.sv =====
// Testbench top for the register file sensor device.
// Drives directed and random bus accesses with random stalls on both channels;
// relies on register_file_sensor_device_checker and rfsd_pkg.
`timescale 1ns / 100ps
module register_file_sensor_device_top_test;

	localparam int NUM_REGS        = rfsd_pkg::REG_COUNT_DEF;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int RANDOM_ACCESSES = 200;
	localparam int IDLE_PCT        = 7;
	localparam int CALM_TX_FIRST   = 80;
	localparam int CALM_TX_LAST    = 140;
	localparam int CALM_RX_FIRST   = 1200;
	localparam int CALM_RX_LAST    = 1800;
	localparam int HOLD_FIRST      = 250;
	localparam int HOLD_CYCLES     = 400;

	localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;

	localparam logic [6:0] BURST_LEN = 7'(rfsd_pkg::MAX_BURST);
	localparam logic [6:0] TOP_BASE  = 7'(NUM_REGS - rfsd_pkg::MAX_BURST);
	localparam logic [6:0] LAST_REG  = 7'(NUM_REGS - 1);

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	rfsd_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_ready;
	rfsd_pkg::rsp_t rsp;
	int             mismatch_count;
	int             rsp_outstanding;
	int             cycle_count;
	int             rx_cycle;
	logic           tx_calm;

	register_file_sensor_device_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	register_file_sensor_device_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.rsp_outstanding (rsp_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hold off once for a long stretch so the block backs up into its input.
	initial begin
		rsp_ready = 1'b0;
		rx_cycle  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_FIRST && rx_cycle < HOLD_FIRST + HOLD_CYCLES)
				rsp_ready <= 1'b0;
			else if (rx_cycle >= CALM_RX_FIRST && rx_cycle < CALM_RX_LAST)
				rsp_ready <= 1'b1;
			else
				rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic rfsd_pkg::req_t make_req(input logic [2:0] kind, input logic [2:0] bus,
		input logic [7:0] ep, input logic [6:0] first, input logic [6:0] count,
		input logic [63:0] data);
		rfsd_pkg::req_t r;
		r.req_type  = kind;
		r.bus_num   = bus;
		r.endpoint  = ep;
		r.reg_index = first;
		r.length    = count;
		r.data_word = data;
		return r;
	endfunction

	function automatic rfsd_pkg::req_t random_access();
		rfsd_pkg::req_t r;
		int             pick;
		int             base;
		int             span;
		pick        = int'($urandom_range(99));
		r.req_type  = rfsd_pkg::REQ_TICK;
		r.bus_num   = 3'($urandom_range(rfsd_pkg::BUS_MAX));
		r.endpoint  = 8'($urandom_range(rfsd_pkg::EP_MAX));
		r.reg_index = 7'($urandom);
		r.length    = 7'($urandom_range(rfsd_pkg::MAX_BURST, 1));
		r.data_word = {$urandom, $urandom};
		base        = ($urandom_range(3) == 0) ? int'($urandom_range(NUM_REGS - 1)) :
			int'($urandom_range(7));
		span        = (NUM_REGS - base < rfsd_pkg::MAX_BURST) ? NUM_REGS - base :
			rfsd_pkg::MAX_BURST;
		if (pick < 12) begin
			r.req_type = 3'($urandom);
			r.bus_num  = 3'($urandom);
			r.endpoint = 8'($urandom);
			r.length   = 7'($urandom);
		end else if (pick < 32) begin
			r.req_type = rfsd_pkg::REQ_TICK;
		end else if (pick < 52) begin
			r.req_type  = rfsd_pkg::REQ_READ;
			r.reg_index = 7'(base);
			r.length    = 7'($urandom_range(span, 1));
		end else if (pick < 72) begin
			r.req_type  = rfsd_pkg::REQ_WRITE;
			r.reg_index = 7'(base);
			r.length    = 7'($urandom_range(span, 1));
		end else if (pick < 86) begin
			r.req_type = rfsd_pkg::REQ_SPI;
		end else begin
			r.req_type  = rfsd_pkg::REQ_MDIO;
			r.reg_index = 7'($urandom_range(rfsd_pkg::MDIO_REGS - 7'd1));
		end
		return r;
	endfunction

	task automatic send_access(input rfsd_pkg::req_t item);
		while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		forever begin
			@(posedge clk);
			if (req_ready)
				break;
		end
		@(negedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		tx_calm   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_access(make_req(rfsd_pkg::REQ_MDIO, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_WRITE, rfsd_pkg::BUS_MAX, rfsd_pkg::EP_MAX, 7'd2,
			BURST_LEN, '1));
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd0, 8'd0, 7'd2, BURST_LEN, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_WRITE, 3'd1, 8'd5, TOP_BASE, BURST_LEN,
			64'h0123_4567_89AB_CDEF));
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd2, 8'd9, LAST_REG, 7'd1, '1));
		// window runs past the last register
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd0, 8'd0, TOP_BASE + 7'd1, BURST_LEN,
			64'd0));
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_WRITE, 3'd0, 8'd0, 7'd0, BURST_LEN + 7'd1, '1));
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd0, 8'd0, 7'h7F, 7'd1, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_READ, rfsd_pkg::BUS_MAX + 3'd1, 8'd0, 7'd0, 7'd1,
			64'd0));
		send_access(make_req(rfsd_pkg::REQ_WRITE, 3'd0, rfsd_pkg::EP_MAX + 8'd1, 7'd4, 7'd1,
			'1));
		send_access(make_req(rfsd_pkg::REQ_SPI, 3'h7, 8'hFF, 7'd0, 7'd1, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_SPI, 3'd0, rfsd_pkg::EP_MAX, 7'h7F, BURST_LEN,
			64'hFEDC_BA98_7654_3210));
		send_access(make_req(rfsd_pkg::REQ_SPI, rfsd_pkg::BUS_MAX, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_SPI, rfsd_pkg::BUS_MAX, 8'd0, 7'd0, 7'h7F, '1));
		send_access(make_req(rfsd_pkg::REQ_MDIO, 3'd1, 8'd1, rfsd_pkg::MDIO_REGS - 7'd1, 7'd0,
			64'd0));
		send_access(make_req(rfsd_pkg::REQ_MDIO, 3'd1, 8'd1, rfsd_pkg::MDIO_REGS, 7'h7F, '1));
		for (int c = REQ_UNKNOWN_FIRST; c <= REQ_UNKNOWN_LAST; c++)
			send_access(make_req(3'(c), 3'd0, 8'd0, 7'd0, 7'd1, 64'd0));
		// start a job, restart it while busy, then let it finish
		send_access(make_req(rfsd_pkg::REQ_WRITE, 3'd0, 8'd0, 7'd0, 7'd2,
			{56'h0, rfsd_pkg::CTL_START} << 8));
		send_access(make_req(rfsd_pkg::REQ_MDIO, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_TICK, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_WRITE, 3'd0, 8'd0, 7'd1, 7'd1,
			{56'h0, rfsd_pkg::CTL_START}));
		send_access(make_req(rfsd_pkg::REQ_TICK, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_TICK, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_TICK, 3'd0, 8'd0, 7'd0, 7'd0, 64'd0));
		send_access(make_req(rfsd_pkg::REQ_READ, 3'd0, 8'd0, 7'd0, 7'd2, 64'd0));

		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			tx_calm = (n >= CALM_TX_FIRST && n < CALM_TX_LAST);
			send_access(random_access());
		end
		req_valid <= 1'b0;

		while (rsp_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
